// ===== hdl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the sextet lookup shared by the key base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int KEY_BYTES   = 32;
   localparam int FULL_GROUPS = KEY_BYTES / 3;
   localparam int TEXT_CHARS  = 4 * FULL_GROUPS + 4;
   localparam int CNT_W       = $clog2(TEXT_CHARS + 1);
   localparam int ACC_W       = 18;
   localparam int MAX_RESULTS = 4;
   localparam int NUM_W       = 3;
   localparam int Q_DEPTH     = 8;
   localparam int Q_PTR_W     = 3;
   localparam int Q_FILL_W    = 4;

   localparam logic [7:0] CHAR_PAD = 8'h3D;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_LENGTH = 2'd1;
   localparam logic [1:0] STATUS_CHAR   = 2'd2;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } b64d_req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] key_byte;
      logic [1:0] status;
      logic       last;
   } b64d_rsp_type;

   typedef struct packed {
      b64d_rsp_type [MAX_RESULTS-1:0] items;
      logic [NUM_W-1:0]               count;
   } b64d_bundle_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } b64d_sextet_type;

   function automatic b64d_sextet_type sextet_of(input logic [7:0] ch);
      b64d_sextet_type s;
      s.ok    = 1'b1;
      s.value = 6'd0;
      if (ch inside {[8'h41:8'h5A]}) begin
         s.value = 6'(ch - 8'h41);
      end else if (ch inside {[8'h61:8'h7A]}) begin
         s.value = 6'(ch - 8'd71);
      end else if (ch inside {[8'h30:8'h39]}) begin
         s.value = 6'(ch + 8'd4);
      end else if (ch == 8'h2B) begin
         s.value = 6'd62;
      end else if (ch == 8'h2F) begin
         s.value = 6'd63;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== hdl/b64d_decode.sv =====
// ----------------------------------------------------------------------------
// b64d_decode
// Group state and per-character decode; builds the results of one item.
// ----------------------------------------------------------------------------
module b64d_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  b64d_pkg::b64d_req_type   item,
   output b64d_pkg::b64d_bundle_type bundle
);
   import b64d_pkg::*;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             char_err_ff, char_err_in;
   logic             len_err_ff, len_err_in;

   always_comb begin
      logic [1:0]       pos;
      logic             closing;
      b64d_sextet_type  s;
      logic [23:0]      v;
      logic [NUM_W-1:0] nb;
      logic [1:0]       st;

      pos         = cnt_ff[1:0];
      closing     = cnt_ff >= CNT_W'(4 * FULL_GROUPS);
      s           = sextet_of(item.ch);
      v           = {acc_ff, s.value};
      nb          = '0;
      st          = STATUS_OK;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      char_err_in = char_err_ff;
      len_err_in  = len_err_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         bundle.items[i] = '{kind: KIND_BYTE, key_byte: 8'd0, status: STATUS_OK, last: 1'b0};
      end

      if (cnt_ff < CNT_W'(TEXT_CHARS)) begin
         if (closing && pos == 2'd3) begin
            if (item.ch != CHAR_PAD) len_err_in = 1'b1;
            if (acc_ff[1:0] != 2'd0) char_err_in = 1'b1;
            bundle.items[0].key_byte = acc_ff[17:10];
            bundle.items[1].key_byte = acc_ff[9:2];
            nb     = NUM_W'(2);
            acc_in = '0;
         end else begin
            if (!s.ok) char_err_in = 1'b1;
            if (pos == 2'd3) begin
               bundle.items[0].key_byte = v[23:16];
               bundle.items[1].key_byte = v[15:8];
               bundle.items[2].key_byte = v[7:0];
               nb     = NUM_W'(3);
               acc_in = '0;
            end else begin
               acc_in = {acc_ff[11:0], s.value};
            end
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         len_err_in = 1'b1;
      end

      bundle.count = nb;
      if (item.end_of_text) begin
         if (cnt_in != CNT_W'(TEXT_CHARS)) len_err_in = 1'b1;
         if (len_err_in) begin
            st = STATUS_LENGTH;
         end else if (char_err_in) begin
            st = STATUS_CHAR;
         end
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (NUM_W'(i) == nb) begin
               bundle.items[i] = '{kind: KIND_STATUS, key_byte: 8'd0, status: st, last: 1'b1};
            end
         end
         bundle.count = nb + NUM_W'(1);
         acc_in       = '0;
         cnt_in       = '0;
         char_err_in  = 1'b0;
         len_err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         cnt_ff      <= '0;
         char_err_ff <= 1'b0;
         len_err_ff  <= 1'b0;
      end else if (fire) begin
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         char_err_ff <= char_err_in;
         len_err_ff  <= len_err_in;
      end
   end

endmodule

// ===== hdl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Result queue: takes up to four items a cycle, hands out one a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  b64d_pkg::b64d_bundle_type bundle,
   output logic                      space_ok,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output b64d_pkg::b64d_rsp_type    rsp_item
);
   import b64d_pkg::*;

   b64d_rsp_type [Q_DEPTH-1:0] q_ff;
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_FILL_W-1:0] fill_ff, fill_in;
   logic [NUM_W-1:0]    push_n;
   logic                pop;

   assign push_n    = push ? bundle.count : '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = fill_ff != '0;
   assign rsp_item  = q_ff[rd_ptr_ff];
   assign space_ok  = fill_ff <= Q_FILL_W'(Q_DEPTH - MAX_RESULTS);
   assign wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop);
   assign fill_in   = fill_ff + Q_FILL_W'(push_n) - Q_FILL_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_DEPTH; i++) begin
         logic [Q_PTR_W-1:0] off;
         off = Q_PTR_W'(i) - wr_ptr_ff;
         if (Q_PTR_W'(off) < Q_PTR_W'(push_n)) begin
            q_ff[i] <= bundle.items[off[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== hdl/key_base64_decoder_top.sv =====
// ----------------------------------------------------------------------------
// key_base64_decoder_top
// Streaming base64 key decoder: characters in, key bytes and status out.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register until the queue has space,
// is decoded as it moves into the result queue, and is then offered on rsp.
// Throughput: one character per cycle; an item holds in the input register
// while the eight-entry result queue has more than four entries waiting.
// Reset clears the group state, error flags, input valid flag, queue pointers and fill.
// ----------------------------------------------------------------------------
module key_base64_decoder_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  b64d_pkg::b64d_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b64d_pkg::b64d_rsp_type rsp_item
);
   import b64d_pkg::*;

   logic            in_valid_ff, in_valid_in;
   b64d_req_type    in_ff;
   b64d_bundle_type bundle;
   logic            space_ok;
   logic            move;

   assign move        = in_valid_ff && space_ok;
   assign req_stall   = in_valid_ff && !space_ok;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_item;
      end
   end

   b64d_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .fire   (move),
      .item   (in_ff),
      .bundle (bundle)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (move),
      .bundle    (bundle),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
